// ===== rtl/core/pke_pkg.sv =====
// Shared types, constants and AES helper functions for the payload keystream encryptor.
package pke_pkg;

   localparam int MAX_MESSAGE_BYTES = 256;
   localparam int POS_W = $clog2(MAX_MESSAGE_BYTES);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [7:0] CTR_BLOCK_TAG = 8'h01;
   localparam logic [3:0] LAST_ROUND = 4'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_LOW = 3'd0,
      CSR_KEY_HIGH = 3'd1,
      CSR_DEVICE_ADDRESS = 3'd2,
      CSR_FRAME_COUNTER = 3'd3,
      CSR_DIRECTION = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       final_byte;
   } req_data_type;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic       end_of_message;
   } rsp_data_type;

   typedef struct packed {
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [31:0] device_address;
      logic [31:0] frame_counter;
      logic        direction;
   } cfg_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       final_byte;
      logic [3:0] offset;
      logic [7:0] block_number;
      logic       new_block;
   } entry_type;

   typedef struct packed {
      logic [127:0] block;
      logic [127:0] key;
   } aes_job_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
      return v[127-8*i -: 8];
   endfunction

   function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                   input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
      w0 = rk[127:96];
      w1 = rk[95:64];
      w2 = rk[63:32];
      w3 = rk[31:0];
      t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      n0 = w0 ^ t;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   function automatic logic [127:0] cipher_round(input logic [127:0] s,
                                                 input logic last);
      logic [7:0] sb [16];
      logic [7:0] sr [16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         sb[i] = SBOX[get_byte(s, i)];
      end
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            sr[4*c+j] = sb[4*((c+j)%4)+j];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = sr[4*c];
         a1 = sr[4*c+1];
         a2 = sr[4*c+2];
         a3 = sr[4*c+3];
         x = a0 ^ a1 ^ a2 ^ a3;
         if (last) begin
            res[127-32*c -: 32] = {a0, a1, a2, a3};
         end else begin
            res[127-32*c -: 32] = {a0 ^ x ^ xtime(a0 ^ a1), a1 ^ x ^ xtime(a1 ^ a2),
                                   a2 ^ x ^ xtime(a2 ^ a3), a3 ^ x ^ xtime(a3 ^ a0)};
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/payload_keystream_encryptor.sv =====
// Top level of the payload keystream encryptor: AES-128 counter-mode payload encryption.
// Bytes stream in one per cycle and leave one per cycle through a registered output while
// neither side stalls. The first byte of each 16-byte block waits at the head of the queue
// for the iterative AES core (a load step, ten rounds and a step to register the keystream);
// the remaining bytes of a block then pass at one per cycle. A four-entry queue lets the
// input keep taking bytes while a keystream block is computed.
module payload_keystream_encryptor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pke_pkg::req_data_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pke_pkg::rsp_data_type               rsp_data,
   input  logic                                csr_write_enable,
   input  logic [pke_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pke_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   pke_pkg::cfg_type   cfg_ff, cfg_in;
   pke_pkg::entry_type push_entry, head;
   logic               push, pop, full, empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pke_pkg::CSR_KEY_LOW:        cfg_in.key_low = csr_write_data;
            pke_pkg::CSR_KEY_HIGH:       cfg_in.key_high = csr_write_data;
            pke_pkg::CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_write_data[31:0];
            pke_pkg::CSR_FRAME_COUNTER:  cfg_in.frame_counter = csr_write_data[31:0];
            pke_pkg::CSR_DIRECTION:      cfg_in.direction = csr_write_data[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pke_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   pke_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   pke_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/pke_front.sv =====
// Front end: accepts payload bytes, tracks the message position and tags each byte.
module pke_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pke_pkg::req_data_type req_data,
   input  logic                  queue_full,
   output logic                  push,
   output pke_pkg::entry_type    push_entry
);

   logic [pke_pkg::POS_W-1:0] pos_ff, pos_in;

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;

   always_comb begin
      push_entry.plain_byte = req_data.plain_byte;
      push_entry.final_byte = req_data.final_byte;
      push_entry.offset = pos_ff[3:0];
      push_entry.block_number = 8'(pos_ff >> 4);
      push_entry.new_block = (pos_ff[3:0] == 4'd0);
   end

   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         if (req_data.final_byte ||
             pos_ff == pke_pkg::POS_W'(pke_pkg::MAX_MESSAGE_BYTES - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/core/pke_queue.sv =====
// Short queue of tagged bytes between the front and back ends.
module pke_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pke_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output pke_pkg::entry_type head
);

   pke_pkg::entry_type               mem_ff [pke_pkg::QUEUE_DEPTH];
   logic [pke_pkg::QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [pke_pkg::QPTR_W:0]         count_ff, count_in;

   assign full = (count_ff == (pke_pkg::QPTR_W+1)'(pke_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/pke_aes.sv =====
// Iterative AES-128 encryption core, one round per cycle with on-the-fly key expansion.
module pke_aes (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  pke_pkg::aes_job_type job,
   output logic                 busy,
   output logic                 done,
   output logic [127:0]         result
);

   logic [127:0] state_ff, state_in, rk_ff, rk_in, rk_next;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic         last;

   assign busy = busy_ff;
   assign done = done_ff;
   assign result = state_ff;
   assign last = (round_ff == pke_pkg::LAST_ROUND);
   assign rk_next = pke_pkg::next_round_key(rk_ff, rcon_ff);

   always_comb begin
      state_in = state_ff;
      rk_in = rk_ff;
      rcon_in = rcon_ff;
      round_in = round_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         state_in = job.block ^ job.key;
         rk_in = job.key;
         rcon_in = 8'h01;
         round_in = 4'd1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         state_in = pke_pkg::cipher_round(state_ff, last) ^ rk_next;
         rk_in = rk_next;
         rcon_in = pke_pkg::xtime(rcon_ff);
         round_in = round_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rk_ff <= rk_in;
      rcon_ff <= rcon_in;
      round_ff <= round_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/core/pke_back.sv =====
// Back end: generates keystream blocks and XORs queued bytes into the result register.
module pke_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pke_pkg::cfg_type      cfg,
   input  logic                  empty,
   input  pke_pkg::entry_type    head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pke_pkg::rsp_data_type rsp_data
);

   pke_pkg::aes_job_type  job;
   pke_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic [127:0]          ks_ff, ks_in, aes_result;
   logic                  ks_ok_ff, ks_ok_in, rsp_valid_ff, rsp_valid_in;
   logic                  aes_busy, aes_done, start, out_free;
   logic [7:0]            ks_byte;

   assign job.key = {cfg.key_high, cfg.key_low};
   assign job.block = {pke_pkg::CTR_BLOCK_TAG, 32'h0, 7'h0, cfg.direction,
                       cfg.device_address[7:0], cfg.device_address[15:8],
                       cfg.device_address[23:16], cfg.device_address[31:24],
                       cfg.frame_counter[7:0], cfg.frame_counter[15:8],
                       cfg.frame_counter[23:16], cfg.frame_counter[31:24],
                       8'h00, head.block_number + 8'd1};

   assign start = !empty && head.new_block && !ks_ok_ff && !aes_busy && !aes_done;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop = !empty && (!head.new_block || ks_ok_ff) && out_free;
   assign ks_byte = 8'(ks_ff >> {~head.offset, 3'b000});
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   pke_aes u_aes (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .job    (job),
      .busy   (aes_busy),
      .done   (aes_done),
      .result (aes_result)
   );

   always_comb begin
      ks_in = aes_done ? aes_result : ks_ff;
      ks_ok_in = ks_ok_ff;
      if (aes_done) begin
         ks_ok_in = 1'b1;
      end else if (pop && head.new_block) begin
         ks_ok_in = 1'b0;
      end
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
      rsp_data_in = rsp_data_ff;
      if (pop) begin
         rsp_data_in.cipher_byte = head.plain_byte ^ ks_byte;
         rsp_data_in.end_of_message = head.final_byte;
      end
   end

   always_ff @(posedge clock) begin
      ks_ff <= ks_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ks_ok_ff <= ks_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== verif/pke_checker.sv =====
// Checker for the payload keystream encryptor: predicts each cipher byte and compares.
`timescale 1ns / 100ps
module pke_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  pke_pkg::req_data_type               req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  pke_pkg::rsp_data_type               rsp_data,
   input  logic                                csr_write_enable,
   input  logic [pke_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pke_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output int                                  error_count,
   output int                                  pending_count,
   output int                                  checked_count
);

   pke_pkg::cfg_type      shadow_cfg;
   logic [7:0]            msg_position;
   logic [127:0]          cur_keystream;
   pke_pkg::rsp_data_type cipher_queue [$];

   function automatic logic [7:0] sub_byte(input logic [7:0] x);
      logic [7:0] tab [256];
      tab = pke_pkg::SBOX;
      return tab[x];
   endfunction

   function automatic logic [7:0] dbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [127:0] pt,
                                                  input logic [127:0] key);
      logic [7:0] rk [176];
      logic [7:0] st [16];
      logic [7:0] tp [16];
      logic [7:0] t [4];
      logic [7:0] rcon, f, a0, a1, a2, a3, s;
      logic [127:0] res;
      rcon = 8'h01;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127-8*i -: 8];
         st[i] = pt[127-8*i -: 8];
      end
      for (int i = 16; i < 176; i += 4) begin
         for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
         if (i % 16 == 0) begin
            f = t[0];
            t[0] = sub_byte(t[1]) ^ rcon;
            t[1] = sub_byte(t[2]);
            t[2] = sub_byte(t[3]);
            t[3] = sub_byte(f);
            rcon = dbl(rcon);
         end
         for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) tp[i] = sub_byte(st[i]);
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++) st[4*c+j] = tp[4*((c+j)%4)+j];
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               s = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ s ^ dbl(a0 ^ a1);
               st[4*c+1] = a1 ^ s ^ dbl(a1 ^ a2);
               st[4*c+2] = a2 ^ s ^ dbl(a2 ^ a3);
               st[4*c+3] = a3 ^ s ^ dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= rk[16*r+i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
      return res;
   endfunction

   function automatic logic [127:0] counter_keystream(input pke_pkg::cfg_type c,
                                                      input logic [3:0] blk);
      logic [127:0] ctr;
      ctr = {pke_pkg::CTR_BLOCK_TAG, 32'h0, 7'h0, c.direction,
             c.device_address[7:0], c.device_address[15:8],
             c.device_address[23:16], c.device_address[31:24],
             c.frame_counter[7:0], c.frame_counter[15:8],
             c.frame_counter[23:16], c.frame_counter[31:24],
             8'h00, 8'({4'h0, blk} + 8'd1)};
      return encrypt_block(ctr, {c.key_high, c.key_low});
   endfunction

   assign pending_count = cipher_queue.size();

   always @(posedge clock) begin
      pke_pkg::rsp_data_type want;
      if (reset) begin
         shadow_cfg <= '0;
         msg_position <= '0;
         error_count <= 0;
         checked_count <= 0;
         cipher_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               pke_pkg::CSR_KEY_LOW:        shadow_cfg.key_low <= csr_write_data;
               pke_pkg::CSR_KEY_HIGH:       shadow_cfg.key_high <= csr_write_data;
               pke_pkg::CSR_DEVICE_ADDRESS: shadow_cfg.device_address <= csr_write_data[31:0];
               pke_pkg::CSR_FRAME_COUNTER:  shadow_cfg.frame_counter <= csr_write_data[31:0];
               pke_pkg::CSR_DIRECTION:      shadow_cfg.direction <= csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            logic [127:0] ks;
            ks = cur_keystream;
            if (msg_position[3:0] == 4'd0) begin
               ks = counter_keystream(shadow_cfg, msg_position[7:4]);
               cur_keystream <= ks;
            end
            want.cipher_byte = req_data.plain_byte ^ ks[127-8*msg_position[3:0] -: 8];
            want.end_of_message = req_data.final_byte;
            cipher_queue.push_back(want);
            msg_position <= req_data.final_byte ? 8'd0 : msg_position + 8'd1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (cipher_queue.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = cipher_queue.pop_front();
               checked_count <= checked_count + 1;
               if (rsp_data.cipher_byte !== want.cipher_byte) begin
                  $display("%0t: cipher_byte expected %h actual %h", $time,
                           want.cipher_byte, rsp_data.cipher_byte);
                  error_count <= error_count + 1;
               end else if (rsp_data.end_of_message !== want.end_of_message) begin
                  $display("%0t: end_of_message expected %b actual %b", $time,
                           want.end_of_message, rsp_data.end_of_message);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== verif/testbench.sv =====
// Top of the payload keystream encryptor testbench: stimulus, idling phases and verdict.
`timescale 1ns / 100ps
module testbench;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   pke_pkg::req_data_type req_data;
   pke_pkg::rsp_data_type rsp_data;
   logic csr_write_enable;
   logic [pke_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pke_pkg::CSR_DATA_W-1:0] csr_write_data;
   int error_count, pending_count, checked_count;
   int send_idle_pct, stall_pct, cycle_count, byte_count, msg_count;
   logic hold_request;

   payload_keystream_encryptor dut (.*);
   pke_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int   hold_left;
      logic hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic write_csr(input pke_pkg::csr_index_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic settle;
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic load_session(input logic [63:0] kl, input logic [63:0] kh,
                               input logic [31:0] addr, input logic [31:0] fcnt,
                               input logic dir);
      settle();
      write_csr(pke_pkg::CSR_KEY_LOW, kl);
      write_csr(pke_pkg::CSR_KEY_HIGH, kh);
      write_csr(pke_pkg::CSR_DEVICE_ADDRESS, {32'h0, addr});
      write_csr(pke_pkg::CSR_FRAME_COUNTER, {32'h0, fcnt});
      write_csr(pke_pkg::CSR_DIRECTION, {63'h0, dir});
   endtask

   task automatic send_byte(input logic [7:0] pb, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{plain_byte: pb, final_byte: fin};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      byte_count++;
      msg_count += fin;
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      hold_request = 0;
      csr_write_enable = 0;
      csr_index = '0;
      csr_write_data = '0;
      byte_count = 0;
      msg_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero config, extremes of bytes, one-byte message, block edge
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      for (int i = 0; i < 18; i++) send_byte(i[0] ? 8'hff : 8'h00, i == 17);
      load_session('1, '1, '1, '1, 1'b1);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h5a, 1'b1);
      load_session(64'h0123456789abcdef, 64'hfedcba9876543210, 32'h26011bda,
                   32'h00000001, 1'b0);
      send_byte(8'h3c, 1'b1);

      // wrap past the maximum message length
      send_message(pke_pkg::MAX_MESSAGE_BYTES + 20);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 10 : 63) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 10 : 63) : 0;
         load_session({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
                      1'($urandom));
         if (ph == 0) begin
            hold_request = 1'b1;
         end
         for (int m = 0; m < 12; m++) begin
            send_message(($urandom_range(9) == 0) ? $urandom_range(60, 120)
                                                   : $urandom_range(1, 40));
         end
      end

      stall_pct = 0;
      settle();
      $display("Covered %0d bytes in %0d messages, %0d results checked,", byte_count,
               msg_count, checked_count);
      $display("over seven register settings and four idling phases.");
      if (error_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/pke_pkg.sv
rtl/core/pke_front.sv
rtl/core/pke_queue.sv
rtl/core/pke_aes.sv
rtl/core/pke_back.sv
rtl/core/payload_keystream_encryptor.sv
verif/pke_checker.sv
verif/testbench.sv
